FILE: rtl/chkm_pkg.sv
// shared types, codes and hash function for the chained hash key map
`timescale 1ns / 1ps
package chkm_pkg;

    // command codes
    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_FIND   = 2'd1;
    localparam logic [1:0] CMD_REMOVE = 2'd2;
    localparam logic [1:0] CMD_CLEAR  = 2'd3;

    // status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_DUPLICATE = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    localparam int KEY_W    = 31;
    localparam int HANDLE_W = 16;
    localparam int COUNT_W  = 7;

    // write enables toward the entry pool
    typedef struct packed {
        logic wr_data;
        logic wr_link;
        logic wr_use;
        logic use_val;
    } t_pool_ctl;

    // xor-shift supplemental hash
    function automatic logic [KEY_W-1:0] key_hash(input logic [KEY_W-1:0] key);
        logic [KEY_W-1:0] h;
        begin
            h = key;
            h = h ^ (h >> 20) ^ (h >> 12);
            h = h ^ (h >> 7) ^ (h >> 4);
            return h;
        end
    endfunction

endpackage

FILE: rtl/chkm_pool.sv
// entry pool memories: keys, handles, chain links and in-use bits
`timescale 1ns / 1ps
module chkm_pool
    import chkm_pkg::*;
#(
    parameter int CAPACITY = 64,
    parameter int IW = 7,
    parameter int AW = 6
) (
    input  logic                i_clk,
    input  t_pool_ctl           i_ctl,
    input  logic [AW-1:0]       i_wr_addr,
    input  logic [KEY_W-1:0]    i_wr_key,
    input  logic [HANDLE_W-1:0] i_wr_handle,
    input  logic [IW-1:0]       i_wr_link,
    input  logic [AW-1:0]       i_rd_addr,
    output logic [KEY_W-1:0]    o_rd_key,
    output logic [HANDLE_W-1:0] o_rd_handle,
    output logic [IW-1:0]       o_rd_link,
    output logic                o_rd_use
);

    logic [KEY_W-1:0]    r_keys    [CAPACITY];
    logic [HANDLE_W-1:0] r_handles [CAPACITY];
    logic [IW-1:0]       r_links   [CAPACITY];
    logic                r_use     [CAPACITY];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_data) begin
            r_keys[i_wr_addr]    <= i_wr_key;
            r_handles[i_wr_addr] <= i_wr_handle;
        end
        if (i_ctl.wr_data || i_ctl.wr_link) begin
            r_links[i_wr_addr] <= i_wr_link;
        end
        if (i_ctl.wr_use) begin
            r_use[i_wr_addr] <= i_ctl.use_val;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        o_rd_key    <= r_keys[i_rd_addr];
        o_rd_handle <= r_handles[i_rd_addr];
        o_rd_link   <= r_links[i_rd_addr];
        o_rd_use    <= r_use[i_rd_addr];
    end

endmodule

FILE: rtl/chained_hash_key_map_core.sv
// top level: command sequencer, bucket head memory and result register
//
// Keyed set of unique 31-bit keys with a 16-bit handle each, kept as a hash
// table with separate chaining over a fixed pool of CAPACITY entries.
// Input channel s_axis: one word per command (insert, find, remove, clear)
// with the command in tuser and key and handle in tdata.
// Output channel m_axis: one word per command with the status in tuser and
// the found handle and entry count in tdata.
// Commands run one at a time; s_axis_tready is high only when idle, which
// starts the cycle after the result word is registered.
// A command reads its bucket head, then walks the chain with one pool read
// per entry passed over; a hit on remove then unlinks the entry. Insert of a
// new key then scans the pool for the lowest free entry and writes it there.
// Clear sweeps the bucket heads and in-use bits and then gives its result.
// The chain walk and the free-slot scan share one pool read port.
// Reset runs the same clearing pass over the bucket heads and in-use bits;
// no word is accepted meanwhile and no result is made.
// A finished result sits in the output register until m_axis_tready; the
// next command waits only until that register is free.
`timescale 1ns / 1ps
module chained_hash_key_map_core
    import chkm_pkg::*;
#(
    parameter int BUCKETS  = 16,
    parameter int CAPACITY = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,  // key[30:0], handle[46:31], zero pad
    input  logic [1:0]  s_axis_tuser,  // command[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,  // found_handle[15:0], entry_count[22:16], pad
    output logic [1:0]  m_axis_tuser   // status[1:0]
);

    localparam int IW    = $clog2(CAPACITY + 1);
    localparam int AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int BW    = $clog2(BUCKETS);
    localparam int MAXBC = (BUCKETS > CAPACITY) ? BUCKETS : CAPACITY;
    localparam int SW    = $clog2(MAXBC);

    localparam logic [IW-1:0] NIL   = IW'(CAPACITY);
    localparam logic [SW:0]   BUCK_L = (SW+1)'(BUCKETS);
    localparam logic [SW:0]   CAP_S  = (SW+1)'(CAPACITY);
    localparam logic [SW-1:0] SWEEP_END = SW'(MAXBC - 1);
    localparam logic [AW-1:0] SCAN_END  = AW'(CAPACITY - 1);
    localparam logic [KEY_W-1:0] BMASK  = KEY_W'(BUCKETS - 1);

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_HRD, S_HEAD, S_WALK, S_CMP,
        S_UNL, S_SCAN, S_SCHK, S_INS, S_DONE
    } t_state;

    t_state r_state, n_state;
    logic                r_init, n_init;
    logic [1:0]          r_cmd, n_cmd;
    logic [KEY_W-1:0]    r_key, n_key;
    logic [HANDLE_W-1:0] r_hdl, n_hdl;
    logic [IW-1:0]       r_cur, n_cur;
    logic [IW-1:0]       r_prev, n_prev;
    logic [IW-1:0]       r_steps, n_steps;
    logic [IW-1:0]       r_head, n_head;
    logic [IW-1:0]       r_hlink, n_hlink;
    logic [SW-1:0]       r_idx, n_idx;
    logic [IW-1:0]       r_count, n_count;
    logic [1:0]          r_status, n_status;
    logic [HANDLE_W-1:0] r_found, n_found;
    logic                r_ovalid, n_ovalid;
    logic [1:0]          r_ostatus, n_ostatus;
    logic [HANDLE_W-1:0] r_ofound, n_ofound;
    logic [COUNT_W-1:0]  r_ocount, n_ocount;

    // bucket head memory
    logic [IW-1:0] r_heads [BUCKETS];
    logic [IW-1:0] r_head_rd;
    logic          head_we;
    logic [BW-1:0] head_wa;
    logic [IW-1:0] head_wd;
    logic [BW-1:0] w_bkt;

    // pool port signals
    t_pool_ctl           pctl;
    logic [AW-1:0]       pwa, pra;
    logic [IW-1:0]       pwlink;
    logic [KEY_W-1:0]    p_key;
    logic [HANDLE_W-1:0] p_hdl;
    logic [IW-1:0]       p_link;
    logic                p_use;

    logic in_acc;

    assign w_bkt  = BW'(key_hash(r_key) & BMASK);
    assign in_acc = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (head_we) begin
            r_heads[head_wa] <= head_wd;
        end
        r_head_rd <= r_heads[w_bkt];
    end

    chkm_pool #(
        .CAPACITY (CAPACITY),
        .IW       (IW),
        .AW       (AW)
    ) u_pool (
        .i_clk       (i_clk),
        .i_ctl       (pctl),
        .i_wr_addr   (pwa),
        .i_wr_key    (r_key),
        .i_wr_handle (r_hdl),
        .i_wr_link   (pwlink),
        .i_rd_addr   (pra),
        .o_rd_key    (p_key),
        .o_rd_handle (p_hdl),
        .o_rd_link   (p_link),
        .o_rd_use    (p_use)
    );

    // sequencer next state
    always_comb begin
        n_state   = r_state;
        n_init    = r_init;
        n_cmd     = r_cmd;
        n_key     = r_key;
        n_hdl     = r_hdl;
        n_cur     = r_cur;
        n_prev    = r_prev;
        n_steps   = r_steps;
        n_head    = r_head;
        n_hlink   = r_hlink;
        n_idx     = r_idx;
        n_count   = r_count;
        n_status  = r_status;
        n_found   = r_found;
        n_ovalid  = r_ovalid;
        n_ostatus = r_ostatus;
        n_ofound  = r_ofound;
        n_ocount  = r_ocount;
        head_we   = 1'b0;
        head_wa   = w_bkt;
        head_wd   = NIL;
        pctl      = '0;
        pwa       = r_cur[AW-1:0];
        pra       = r_cur[AW-1:0];
        pwlink    = r_hlink;

        if (r_ovalid && m_axis_tready) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            // sweep bucket heads and in-use bits
            S_CLR: begin
                if ({1'b0, r_idx} < BUCK_L) begin
                    head_we = 1'b1;
                    head_wa = r_idx[BW-1:0];
                end
                if ({1'b0, r_idx} < CAP_S) begin
                    pctl.wr_use  = 1'b1;
                    pctl.use_val = 1'b0;
                    pwa          = r_idx[AW-1:0];
                end
                if (r_idx == SWEEP_END) begin
                    n_idx    = '0;
                    n_count  = '0;
                    n_status = ST_OK;
                    n_found  = '0;
                    n_init   = 1'b0;
                    n_state  = r_init ? S_IDLE : S_DONE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_IDLE: begin
                if (in_acc) begin
                    n_cmd = s_axis_tuser;
                    n_key = s_axis_tdata[30:0];
                    n_hdl = s_axis_tdata[46:31];
                    n_idx = '0;
                    n_state = (s_axis_tuser == CMD_CLEAR) ? S_CLR : S_HRD;
                end
            end
            S_HRD: begin
                n_state = S_HEAD;
            end
            S_HEAD: begin
                n_cur   = r_head_rd;
                n_head  = r_head_rd;
                n_prev  = NIL;
                n_steps = '0;
                n_state = S_WALK;
            end
            // end of chain or issue the entry read
            S_WALK: begin
                if (r_cur >= NIL || r_steps >= NIL) begin
                    if (r_cmd == CMD_INSERT) begin
                        n_idx   = '0;
                        n_state = S_SCAN;
                    end else begin
                        n_status = ST_NOT_FOUND;
                        n_found  = '0;
                        n_state  = S_DONE;
                    end
                end else begin
                    n_state = S_CMP;
                end
            end
            // key compare on the entry just read
            S_CMP: begin
                if (p_key == r_key) begin
                    n_found = '0;
                    case (r_cmd)
                        CMD_INSERT: begin
                            n_status = ST_DUPLICATE;
                            n_state  = S_DONE;
                        end
                        CMD_FIND: begin
                            n_status = ST_OK;
                            n_found  = p_hdl;
                            n_state  = S_DONE;
                        end
                        default: begin
                            pctl.wr_use  = 1'b1;
                            pctl.use_val = 1'b0;
                            n_hlink      = p_link;
                            n_state      = S_UNL;
                        end
                    endcase
                end else begin
                    n_prev  = r_cur;
                    n_cur   = p_link;
                    n_steps = r_steps + 1'b1;
                    n_state = S_WALK;
                end
            end
            // unlink the removed entry
            S_UNL: begin
                if (r_prev == NIL) begin
                    head_we = 1'b1;
                    head_wd = r_hlink;
                end else begin
                    pctl.wr_link = 1'b1;
                    pwa          = r_prev[AW-1:0];
                end
                if (r_count != '0) begin
                    n_count = r_count - 1'b1;
                end
                n_status = ST_OK;
                n_state  = S_DONE;
            end
            S_SCAN: begin
                pra     = r_idx[AW-1:0];
                n_state = S_SCHK;
            end
            // lowest free entry search
            S_SCHK: begin
                if (!p_use) begin
                    n_state = S_INS;
                end else if (r_idx[AW-1:0] == SCAN_END) begin
                    n_status = ST_FULL;
                    n_found  = '0;
                    n_state  = S_DONE;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = S_SCAN;
                end
            end
            // link new entry at the chain head
            S_INS: begin
                pctl.wr_data = 1'b1;
                pctl.wr_use  = 1'b1;
                pctl.use_val = 1'b1;
                pwa          = r_idx[AW-1:0];
                pwlink       = r_head;
                head_we      = 1'b1;
                head_wd      = IW'(r_idx);
                n_count      = r_count + 1'b1;
                n_status     = ST_OK;
                n_found      = '0;
                n_state      = S_DONE;
            end
            // hand the result word to the output register
            S_DONE: begin
                if (!r_ovalid || m_axis_tready) begin
                    n_ovalid  = 1'b1;
                    n_ostatus = r_status;
                    n_ofound  = r_found;
                    n_ocount  = COUNT_W'(r_count);
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_init   <= 1'b1;
            r_idx    <= '0;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_init   <= n_init;
            r_idx    <= n_idx;
            r_count  <= n_count;
            r_ovalid <= n_ovalid;
        end
        r_cmd     <= n_cmd;
        r_key     <= n_key;
        r_hdl     <= n_hdl;
        r_cur     <= n_cur;
        r_prev    <= n_prev;
        r_steps   <= n_steps;
        r_head    <= n_head;
        r_hlink   <= n_hlink;
        r_status  <= n_status;
        r_found   <= n_found;
        r_ostatus <= n_ostatus;
        r_ofound  <= n_ofound;
        r_ocount  <= n_ocount;
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tuser  = r_ostatus;
    assign m_axis_tdata  = {1'b0, r_ocount, r_ofound};

endmodule

FILE: rtl/chkm_checker.sv
// port checker for the chained hash key map, bound to the top level
`timescale 1ns / 1ps
module chkm_checker
    import chkm_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);

    // no result word right out of reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result word valid after reset");

    // one command at a time
    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input ready right after an accepted word");

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result word changed while stalled");

    // count within pool size
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[22:16] <= COUNT_W'(CAPACITY))
        else $error("entry count above capacity");

    // handle only on a good status
    a_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser != ST_OK |-> m_axis_tdata[15:0] == '0)
        else $error("found handle set on a failed command");

endmodule

bind chained_hash_key_map_core chkm_checker #(
    .CAPACITY (CAPACITY)
) u_chkm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

FILE: verif/tb_chained_hash_key_map_core.sv
// testbench for the chained hash key map core: directed and random commands
`timescale 1ns / 1ps
module tb_chained_hash_key_map_core;
    import chkm_pkg::*;

    localparam int NBUCK = 16;
    localparam int NPOOL = 64;
    localparam int CYCLE_LIMIT = 5000000;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata;   // key[30:0], handle[46:31], zero pad
    logic [1:0]  s_axis_tuser;   // command[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;   // found_handle[15:0], entry_count[22:16], pad
    logic [1:0]  m_axis_tuser;   // status[1:0]

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] handle;
        logic [6:0]  count;
    } t_reply;

    // shadow copy of the table
    logic [6:0]  sh_heads [NBUCK];
    logic [30:0] sh_keys [NPOOL];
    logic [15:0] sh_handles [NPOOL];
    logic [6:0]  sh_links [NPOOL];
    logic        sh_used [NPOOL];
    logic [6:0]  sh_count;

    t_reply      pending_replies [$];
    logic [30:0] known_keys [$];
    int          error_count;
    int          cycle_count;
    bit          rx_stall_on;

    chained_hash_key_map_core #(.BUCKETS(NBUCK), .CAPACITY(NPOOL)) i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // bucket index from the xor-shift spread
    function automatic int bucket_index(input logic [30:0] key);
        logic [30:0] h;
        h = key;
        h = h ^ (h >> 20) ^ (h >> 12);
        h = h ^ (h >> 7) ^ (h >> 4);
        return int'(h) & (NBUCK - 1);
    endfunction

    function automatic void clear_table();
        for (int i = 0; i < NBUCK; i++) sh_heads[i] = 7'(NPOOL);
        for (int i = 0; i < NPOOL; i++) begin
            sh_used[i] = 1'b0;
            sh_keys[i] = '0;
            sh_handles[i] = '0;
            sh_links[i] = '0;
        end
        sh_count = '0;
    endfunction

    // apply one command to the shadow table and return the reply it gives
    function automatic t_reply apply_command(input logic [1:0] cmd,
                                             input logic [30:0] key,
                                             input logic [15:0] hnd);
        t_reply r;
        int b, cur, prv, hit, steps, slot;
        r = '0;
        b = bucket_index(key);
        cur = sh_heads[b];
        prv = NPOOL;
        hit = NPOOL;
        steps = 0;
        slot = NPOOL;
        while (cur < NPOOL && steps < NPOOL && hit == NPOOL) begin
            if (sh_keys[cur] == key) hit = cur;
            else begin
                prv = cur;
                cur = sh_links[cur];
                steps++;
            end
        end
        case (cmd)
            CMD_INSERT: begin
                if (hit != NPOOL) r.status = ST_DUPLICATE;
                else begin
                    for (int i = NPOOL - 1; i >= 0; i--) if (!sh_used[i]) slot = i;
                    if (slot == NPOOL) r.status = ST_FULL;
                    else begin
                        sh_keys[slot] = key;
                        sh_handles[slot] = hnd;
                        sh_links[slot] = sh_heads[b];
                        sh_used[slot] = 1'b1;
                        sh_heads[b] = 7'(slot);
                        sh_count++;
                    end
                end
            end
            CMD_FIND: begin
                if (hit != NPOOL) r.handle = sh_handles[hit];
                else r.status = ST_NOT_FOUND;
            end
            CMD_REMOVE: begin
                if (hit == NPOOL) r.status = ST_NOT_FOUND;
                else begin
                    if (prv == NPOOL) sh_heads[b] = sh_links[hit];
                    else sh_links[prv] = sh_links[hit];
                    sh_used[hit] = 1'b0;
                    if (sh_count > 0) sh_count--;
                end
            end
            default: clear_table();
        endcase
        r.count = sh_count;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        error_count++;
    endtask

    // send one command word, with a random gap first
    task automatic send_command(input logic [1:0] cmd, input logic [30:0] key,
                                input logic [15:0] hnd);
        int gap;
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30)
            : (($urandom_range(0, 2) == 0) ? $urandom_range(0, 3) : 0);
        repeat (gap + 1) @(posedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {1'b0, hnd, key};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        pending_replies.push_back(apply_command(cmd, key, hnd));
        if (cmd == CMD_INSERT) known_keys.push_back(key);
        if (cmd == CMD_CLEAR) known_keys.delete();
        s_axis_tvalid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_replies.size() != 0) @(posedge i_clk);
    endtask

    // receiver stalls
    always @(posedge i_clk) begin
        if (!rx_stall_on) m_axis_tready <= 1'b1;
        else if ($urandom_range(0, 19) == 0) m_axis_tready <= 1'b0;
        else if ($urandom_range(0, 3) == 0) m_axis_tready <= 1'b1;
    end

    // result checker
    always @(posedge i_clk) begin
        t_reply want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_replies.size() == 0) begin
                $display("unexpected result word");
                error_count++;
            end else begin
                want = pending_replies.pop_front();
                if (m_axis_tuser != want.status)
                    report_mismatch("status", m_axis_tuser, want.status);
                if (m_axis_tdata[15:0] != want.handle)
                    report_mismatch("found_handle", m_axis_tdata[15:0], want.handle);
                if (m_axis_tdata[22:16] != want.count)
                    report_mismatch("entry_count", m_axis_tdata[22:16], want.count);
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_chained_hash_key_map_core: errors");
            $finish;
        end
    end

    function automatic logic [30:0] pick_key();
        if (known_keys.size() != 0 && $urandom_range(0, 2) != 0)
            return known_keys[$urandom_range(0, known_keys.size() - 1)];
        if ($urandom_range(0, 1) == 0) return 31'($urandom_range(0, 150));
        return 31'($urandom());
    endfunction

    // field extremes and the miss, duplicate, hit, remove and clear cases
    task automatic test_directed();
        send_command(CMD_FIND, 31'h0, 16'h0);
        send_command(CMD_REMOVE, 31'h7FFF_FFFF, 16'hFFFF);
        send_command(CMD_INSERT, 31'h0, 16'hFFFF);
        send_command(CMD_INSERT, 31'h7FFF_FFFF, 16'h0);
        send_command(CMD_INSERT, 31'h0, 16'h1234);
        send_command(CMD_FIND, 31'h0, 16'h0);
        send_command(CMD_FIND, 31'h7FFF_FFFF, 16'hFFFF);
        send_command(CMD_REMOVE, 31'h0, 16'h0);
        send_command(CMD_FIND, 31'h0, 16'h0);
        send_command(CMD_CLEAR, 31'h5555_5555, 16'hAAAA);
        send_command(CMD_FIND, 31'h7FFF_FFFF, 16'h0);
    endtask

    // fill the pool, then overflow and repeat a key while full
    task automatic test_full_pool();
        for (int i = 0; i < NPOOL + 3; i++)
            send_command(CMD_INSERT, 31'(i * 16), 16'($urandom()));
        send_command(CMD_INSERT, 31'h10, 16'h0);
        // remove the entry at the end of its chain and refill the slot
        send_command(CMD_REMOVE, 31'(16 * 5), 16'h0);
        send_command(CMD_INSERT, 31'h7FFF_0000, 16'hBEEF);
        send_command(CMD_FIND, 31'h7FFF_0000, 16'h0);
        wait_drained();
        send_command(CMD_CLEAR, 31'h0, 16'h0);
    endtask

    // random mix, biased toward keys already seen
    task automatic test_random(input int n);
        int c;
        for (int i = 0; i < n; i++) begin
            c = $urandom_range(0, 99);
            if (c < 45) send_command(CMD_INSERT, pick_key(), 16'($urandom()));
            else if (c < 72) send_command(CMD_FIND, pick_key(), 16'($urandom()));
            else if (c < 99) send_command(CMD_REMOVE, pick_key(), 16'($urandom()));
            else send_command(CMD_CLEAR, pick_key(), 16'($urandom()));
            if (i == n / 2) wait_drained();
        end
    endtask

    initial begin
        error_count = 0;
        cycle_count = 0;
        rx_stall_on = 1'b0;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        m_axis_tready = 1'b1;
        clear_table();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        rx_stall_on = 1'b1;
        test_full_pool();
        test_random(700);
        rx_stall_on = 1'b0;
        test_random(300);
        rx_stall_on = 1'b1;
        test_random(400);
        wait_drained();
        repeat (400) @(posedge i_clk);
        if (error_count == 0 && pending_replies.size() == 0)
            $display("tb_chained_hash_key_map_core: clean");
        else
            $display("tb_chained_hash_key_map_core: errors");
        $finish;
    end

endmodule
